>>> hdl/hcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hcd_pkg;

    localparam int DEFAULT_MAX_FRAME = 256;

    localparam int BYTE_W = 8;
    localparam int CMD_W  = 10;
    localparam int PAY_W  = 8;

    localparam logic [7:0] CHAR_CR     = 8'h0d;
    localparam logic [7:0] CHAR_LF     = 8'h0a;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] HEX_ALPHA   = 8'h37;
    localparam logic [7:0] PAY_MAX     = 8'hff;

    // bytes in a frame that are not payload: three command digits, two hex, CR, LF
    localparam int FRAME_OVERHEAD = 7;
    localparam int CMD_DIGITS     = 3;

    // byte taken from the input register
    typedef struct packed {
        logic             valid;
        logic [BYTE_W-1:0] data;
    } t_byte_stage;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'h0, nib};
        if (nib < 4'd10) begin
            hex_char = wide + CHAR_ZERO;
        end else begin
            hex_char = wide + HEX_ALPHA;
        end
    endfunction

endpackage

`default_nettype wire

>>> hdl/hcd_rx_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface hcd_rx_if
    import hcd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> hdl/hcd_res_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface hcd_res_if
    import hcd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              checksum_ok;
    logic [CMD_W-1:0]  command_code;
    logic [PAY_W-1:0]  payload_length;
    logic [BYTE_W-1:0] computed_sum;
    logic              too_long;

    modport source (output valid, output checksum_ok, output command_code,
                    output payload_length, output computed_sum, output too_long,
                    input ready);
    modport sink   (input valid, input checksum_ok, input command_code,
                    input payload_length, input computed_sum, input too_long,
                    output ready);
endinterface

`default_nettype wire

>>> hdl/hcd_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module hcd_in_stage
    import hcd_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    hcd_rx_if.sink       i_rx,
    input  wire          i_advance,
    output t_byte_stage  o_stage
);

    logic              r_valid;
    logic              n_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              in_ready;

    // take a new byte when empty or when the held one moves on
    assign in_ready   = !r_valid || i_advance;
    assign i_rx.ready = in_ready;
    assign n_valid    = in_ready ? i_rx.valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_rx.valid) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.data  = r_byte;

endmodule

`default_nettype wire

>>> hdl/hcd_frame_core.sv
`timescale 1ns / 1ps
`default_nettype none

module hcd_frame_core
    import hcd_pkg::*;
#(
    parameter int MAX_FRAME = DEFAULT_MAX_FRAME
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  t_byte_stage  i_stage,
    output logic         o_advance,
    hcd_res_if.source    o_res
);

    localparam int CW = $clog2(MAX_FRAME + 1);
    localparam int XW = (CW > PAY_W) ? CW : PAY_W + 1;

    // frame state
    logic [CW-1:0]     r_count,  n_count;
    logic [BYTE_W-1:0] r_sum,    n_sum;
    logic [BYTE_W-1:0] r_rec0,   n_rec0;
    logic [BYTE_W-1:0] r_rec1,   n_rec1;
    logic [BYTE_W-1:0] r_rec2,   n_rec2;
    logic [CMD_W-1:0]  r_cmd,    n_cmd;
    logic              r_stop,   n_stop;
    logic              r_ovf,    n_ovf;

    // result register
    logic              r_out_valid, n_out_valid;
    logic              r_ok,   n_ok;
    logic [CMD_W-1:0]  r_code, n_code;
    logic [PAY_W-1:0]  r_pay,  n_pay;
    logic [BYTE_W-1:0] r_csum, n_csum;
    logic              r_long, n_long;

    logic              proc;
    logic              is_end;
    logic              frame_long;
    logic [CW-1:0]     pay_diff;
    logic [XW-1:0]     pay_ext;
    logic [CMD_W-1:0]  cmd_x10;
    logic [3:0]        digit;
    logic              is_digit;

    assign o_advance = !r_out_valid || o_res.ready;
    assign proc      = i_stage.valid && o_advance;

    assign is_end     = (i_stage.data == CHAR_LF) && (r_count != '0) && (r_rec0 == CHAR_CR);
    assign frame_long = r_ovf || (r_count >= CW'(MAX_FRAME));

    assign pay_diff = r_count - CW'(FRAME_OVERHEAD - 1);
    assign pay_ext  = XW'(pay_diff);

    assign digit    = 4'(i_stage.data - CHAR_ZERO);
    assign is_digit = (i_stage.data >= CHAR_ZERO) && (i_stage.data <= CHAR_NINE);
    assign cmd_x10  = CMD_W'({r_cmd, 3'b000}) + CMD_W'({r_cmd, 1'b0});

    always_comb begin
        n_count = r_count;
        n_sum   = r_sum;
        n_rec0  = r_rec0;
        n_rec1  = r_rec1;
        n_rec2  = r_rec2;
        n_cmd   = r_cmd;
        n_stop  = r_stop;
        n_ovf   = r_ovf;

        n_ok   = r_ok;
        n_code = r_code;
        n_pay  = r_pay;
        n_csum = r_csum;
        n_long = r_long;

        n_out_valid = o_advance ? (proc && is_end) : r_out_valid;

        if (proc) begin
            if (is_end) begin
                if (frame_long) begin
                    n_ok   = 1'b0;
                    n_code = '0;
                    n_pay  = '0;
                    n_csum = '0;
                    n_long = 1'b1;
                end else begin
                    n_ok   = 1'b0;
                    n_pay  = '0;
                    // frame of at least seven bytes: count before LF is six or more
                    if (r_count >= CW'(FRAME_OVERHEAD - 1)) begin
                        n_ok = (r_rec2 == hex_char(r_sum[7:4])) &&
                               (r_rec1 == hex_char(r_sum[3:0]));
                        n_pay = (pay_ext > XW'(PAY_MAX)) ? PAY_MAX : pay_ext[PAY_W-1:0];
                    end
                    n_code = r_cmd;
                    n_csum = r_sum;
                    n_long = 1'b0;
                end
                n_count = '0;
                n_sum   = '0;
                n_rec0  = '0;
                n_rec1  = '0;
                n_rec2  = '0;
                n_cmd   = '0;
                n_stop  = 1'b0;
                n_ovf   = 1'b0;
            end else begin
                if (r_count >= CW'(CMD_DIGITS)) begin
                    n_sum = r_sum + r_rec2;
                end
                n_rec2 = r_rec1;
                n_rec1 = r_rec0;
                n_rec0 = i_stage.data;

                if ((r_count < CW'(CMD_DIGITS)) && !r_stop) begin
                    if (is_digit) begin
                        n_cmd = cmd_x10 + CMD_W'(digit);
                    end else begin
                        n_stop = 1'b1;
                    end
                end

                // saturate the count and mark the frame as oversized
                if (r_count >= CW'(MAX_FRAME)) begin
                    n_ovf = 1'b1;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_sum       <= '0;
            r_rec0      <= '0;
            r_rec1      <= '0;
            r_rec2      <= '0;
            r_cmd       <= '0;
            r_stop      <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_rec0      <= n_rec0;
            r_rec1      <= n_rec1;
            r_rec2      <= n_rec2;
            r_cmd       <= n_cmd;
            r_stop      <= n_stop;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok   <= n_ok;
        r_code <= n_code;
        r_pay  <= n_pay;
        r_csum <= n_csum;
        r_long <= n_long;
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.checksum_ok    = r_ok;
    assign o_res.command_code   = r_code;
    assign o_res.payload_length = r_pay;
    assign o_res.computed_sum   = r_csum;
    assign o_res.too_long       = r_long;

endmodule

`default_nettype wire

>>> hdl/ascii_hex_checksum_deframer.sv
// The LF that ends a frame passes through the input register and then the result register,
// from which the result transfers. Throughput: one byte per cycle unless stalled; the
// running sum and three-byte history update in one pass. A result waiting on the output
// holds the byte in the input register; intake stops once both registers are full and
// resumes at the edge where the waiting result transfers.
// Reset (synchronous, active low) clears all frame state and both valid flags.
`timescale 1ns / 1ps
`default_nettype none

module ascii_hex_checksum_deframer
    import hcd_pkg::*;
#(
    parameter int MAX_FRAME = DEFAULT_MAX_FRAME
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    hcd_rx_if.sink       i_rx,
    hcd_res_if.source    o_res
);

    t_byte_stage stage;
    logic        advance;

    hcd_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rx      (i_rx),
        .i_advance (advance),
        .o_stage   (stage)
    );

    hcd_frame_core #(
        .MAX_FRAME (MAX_FRAME)
    ) u_frame_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_stage   (stage),
        .o_advance (advance),
        .o_res     (o_res)
    );

    // a discarded frame reports nothing but the flag
    a_long_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.too_long) |->
            (!o_res.checksum_ok && o_res.command_code == '0 &&
             o_res.payload_length == '0 && o_res.computed_sum == '0))
        else $error("oversized frame result carries data");

    // a match never comes from a discarded frame
    a_ok_hex : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.checksum_ok) |-> !o_res.too_long)
        else $error("checksum match on oversized frame");

    a_cmd_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.command_code <= CMD_W'(999)))
        else $error("command code out of range");

    // hold a waiting result until it transfers
    a_no_drop : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |=> o_res.valid)
        else $error("result dropped while stalled");

endmodule

`default_nettype wire
